### hdl/wbmp_pkg.sv
// Shared constants and types for the WBMP row padder.
package wbmp_pkg;

  localparam int DIM_BITS = 12;
  localparam int V_BITS   = DIM_BITS + 7;
  localparam int COL_BITS = DIM_BITS - 2;
  localparam int OUT_DIM_BITS = 12;

  localparam logic [V_BITS-1:0] DIM_MAX = V_BITS'((1 << DIM_BITS) - 1);

  typedef enum logic [1:0] {
    KIND_PIX     = 2'd0,
    KIND_DIMS    = 2'd1,
    KIND_BADTYPE = 2'd2,
    KIND_TOOBIG  = 2'd3
  } kind_t;

  // First result of one input word, handed from the decoder to the output stage.
  typedef struct packed {
    logic                    has_res;
    kind_t                   kind;
    logic [7:0]              data;
    logic [OUT_DIM_BITS-1:0] width;
    logic [OUT_DIM_BITS-1:0] height;
    logic [1:0]              pads;
    logic                    row_end;
    logic                    last_row;
    logic                    image_last;
  } res_t;

endpackage

### hdl/wbmp_row_padder.sv
// Top level of the WBMP row padder.
// A result word is registered and appears in the cycle after its input word is accepted.
// One input word per cycle while out_ready is high; a row-ending word holds the input
// until its pad words (up to three) have drained from the single result register.
// Reset (rst_n low, synchronous): parser expects a type byte, all counters and
// dimensions clear, no result pending.
module wbmp_row_padder (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_kind,
  output logic [7:0]                         out_data_byte,
  output logic [wbmp_pkg::OUT_DIM_BITS-1:0]  out_pix_width,
  output logic [wbmp_pkg::OUT_DIM_BITS-1:0]  out_pix_height,
  output logic                               out_row_last,
  output logic                               out_image_last,
  output logic                               out_run_last
);
  import wbmp_pkg::*;

  res_t res;
  logic accept;
  logic slot_free;

  // Take a new word whenever the result register is empty or drains its
  // last word in this cycle; header words with no result go through too.
  assign in_ready = slot_free;
  assign accept   = in_valid && in_ready;

  // Parse the header, track columns and rows, and build the first result.
  wbmp_hdr_dec u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_byte),
    .res     (res)
  );

  // Hold the result and append the zero pad words at a row end.
  wbmp_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (accept && res.has_res),
    .res            (res),
    .slot_free      (slot_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_data_byte  (out_data_byte),
    .out_pix_width  (out_pix_width),
    .out_pix_height (out_pix_height),
    .out_row_last   (out_row_last),
    .out_image_last (out_image_last),
    .out_run_last   (out_run_last)
  );

  // A run that is not finished keeps the result channel busy next cycle.
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_run_last |=> out_valid)
    else $error("result run ended early");

  // Input stalls only behind a pending result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty result register");

  // Header and error results are single words and never close a row.
  a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_PIX |-> out_run_last && !out_row_last)
    else $error("non-pixel result not a single word");

  // The end of an image is always the end of a run.
  a_image_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_image_last |-> out_run_last)
    else $error("image end inside a run");

endmodule

### hdl/wbmp_hdr_dec.sv
// Header parser and row tracker: turns one input word into a result descriptor.
module wbmp_hdr_dec (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  output wbmp_pkg::res_t res
);
  import wbmp_pkg::*;

  typedef enum logic [4:0] {
    PH_TYPE   = 5'b00001,
    PH_FIXHDR = 5'b00010,
    PH_WIDTH  = 5'b00100,
    PH_HEIGHT = 5'b01000,
    PH_PIXELS = 5'b10000
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [DIM_BITS-1:0] accum_r, accum_nxt;
  logic [DIM_BITS-1:0] width_r, width_nxt;
  logic [DIM_BITS-1:0] height_r, height_nxt;
  logic [COL_BITS-1:0] col_r, col_nxt;
  logic [DIM_BITS-1:0] row_r, row_nxt;

  logic [V_BITS-1:0]   v;
  logic [DIM_BITS:0]   w_ext;
  logic [COL_BITS-1:0] nbytes;
  logic [COL_BITS-1:0] col_inc;
  logic [DIM_BITS-1:0] row_inc;
  logic [1:0]          pads;
  logic                last_row;
  logic                empty;

  always_comb begin
    v       = {accum_r, in_byte[6:0]};
    w_ext   = (DIM_BITS+1)'(width_r) + (DIM_BITS+1)'(7);
    nbytes  = COL_BITS'(w_ext >> 3);
    col_inc = col_r + COL_BITS'(1);
    row_inc = row_r + DIM_BITS'(1);
    // pad count brings the row up to a multiple of four bytes
    pads     = 2'(3'd4 - {1'b0, nbytes[1:0]});
    last_row = (row_inc >= height_r);
    empty    = (width_r == '0) || (v[DIM_BITS-1:0] == '0);

    phase_nxt  = phase_r;
    accum_nxt  = accum_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    res        = '0;
    res.kind   = KIND_PIX;

    case (phase_r)
      PH_TYPE: begin
        if (in_byte != 8'h00) begin
          res.has_res    = 1'b1;
          res.kind       = KIND_BADTYPE;
          res.image_last = 1'b1;
        end else begin
          phase_nxt = PH_FIXHDR;
        end
      end
      PH_FIXHDR: begin
        accum_nxt = '0;
        phase_nxt = PH_WIDTH;
      end
      PH_WIDTH, PH_HEIGHT: begin
        if (v > DIM_MAX) begin
          res.has_res    = 1'b1;
          res.kind       = KIND_TOOBIG;
          res.image_last = 1'b1;
          accum_nxt      = '0;
          phase_nxt      = PH_TYPE;
        end else if (in_byte[7]) begin
          accum_nxt = v[DIM_BITS-1:0];
        end else begin
          accum_nxt = '0;
          if (phase_r == PH_WIDTH) begin
            width_nxt = v[DIM_BITS-1:0];
            phase_nxt = PH_HEIGHT;
          end else begin
            height_nxt     = v[DIM_BITS-1:0];
            col_nxt        = '0;
            row_nxt        = '0;
            res.has_res    = 1'b1;
            res.kind       = KIND_DIMS;
            res.width      = OUT_DIM_BITS'(width_r);
            res.height     = OUT_DIM_BITS'(v[DIM_BITS-1:0]);
            res.image_last = empty;
            phase_nxt      = empty ? PH_TYPE : PH_PIXELS;
          end
        end
      end
      PH_PIXELS: begin
        res.has_res = 1'b1;
        res.data    = in_byte;
        if (col_inc < nbytes) begin
          col_nxt = col_inc;
        end else begin
          col_nxt        = '0;
          res.pads       = pads;
          res.row_end    = 1'b1;
          res.last_row   = last_row;
          res.image_last = (pads == 2'd0) && last_row;
          row_nxt        = last_row ? '0 : row_inc;
          if (last_row) begin
            phase_nxt = PH_TYPE;
          end
        end
      end
      default: begin
        phase_nxt = PH_TYPE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TYPE;
      accum_r  <= '0;
      width_r  <= '0;
      height_r <= '0;
      col_r    <= '0;
      row_r    <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      accum_r  <= accum_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

endmodule

### hdl/wbmp_emit.sv
// Result register: holds a descriptor and plays out its word plus any pad words.
module wbmp_emit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load,
  input  wbmp_pkg::res_t                       res,
  output logic                                 slot_free,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_kind,
  output logic [7:0]                           out_data_byte,
  output logic [wbmp_pkg::OUT_DIM_BITS-1:0]    out_pix_width,
  output logic [wbmp_pkg::OUT_DIM_BITS-1:0]    out_pix_height,
  output logic                                 out_row_last,
  output logic                                 out_image_last,
  output logic                                 out_run_last
);
  import wbmp_pkg::*;

  logic                    valid_r;
  kind_t                   kind_r;
  logic [7:0]              data_r;
  logic [OUT_DIM_BITS-1:0] width_r;
  logic [OUT_DIM_BITS-1:0] height_r;
  logic                    row_last_r;
  logic                    image_last_r;
  logic                    run_last_r;
  logic [1:0]              pad_left_r;
  logic                    last_row_r;
  logic                    pad_end;

  assign slot_free = !valid_r || (out_ready && pad_left_r == 2'd0);
  assign pad_end   = (pad_left_r == 2'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      pad_left_r <= 2'd0;
    end else if (load) begin
      valid_r    <= 1'b1;
      pad_left_r <= res.pads;
    end else if (valid_r && out_ready) begin
      if (pad_left_r != 2'd0) begin
        pad_left_r <= pad_left_r - 2'd1;
      end else begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r       <= res.kind;
      data_r       <= res.data;
      width_r      <= res.width;
      height_r     <= res.height;
      // a pixel word closes its row when it ends the row and no pad follows
      row_last_r   <= (res.kind == KIND_PIX) && res.row_end && (res.pads == 2'd0);
      image_last_r <= res.image_last;
      run_last_r   <= (res.pads == 2'd0);
      last_row_r   <= res.last_row;
    end else if (valid_r && out_ready && pad_left_r != 2'd0) begin
      // advance to the next zero pad word
      kind_r       <= KIND_PIX;
      data_r       <= 8'h00;
      width_r      <= '0;
      height_r     <= '0;
      row_last_r   <= pad_end;
      image_last_r <= pad_end && last_row_r;
      run_last_r   <= pad_end;
    end
  end

  assign out_valid      = valid_r;
  assign out_kind       = kind_r;
  assign out_data_byte  = data_r;
  assign out_pix_width  = width_r;
  assign out_pix_height = height_r;
  assign out_row_last   = row_last_r;
  assign out_image_last = image_last_r;
  assign out_run_last   = run_last_r;

endmodule
